>>> rtl/ftsm_pkg.sv
package ftsm_pkg;

	// Field widths fixed by the item formats.
	localparam int DUR_W    = 16;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 16;
	localparam int SKIP_W   = 9;
	localparam int SUM_W    = 32;
	localparam int FPS_W    = 15;
	localparam int AVG_W    = 23;
	localparam int WIN_W    = 16;
	localparam int CAP_W    = 8;

	// Widths of the two divisions: valid*100000 / sum and sum*100 / valid.
	localparam int FPS_NUM_W = 33;
	localparam int AVG_NUM_W = 39;

	// Scaling constants for the report arithmetic.
	localparam int FPS_SCALE = 100000;
	localparam int CENTI     = 100;
	localparam logic [AVG_W-1:0]  AVG_SAT  = {AVG_W{1'b1}};
	localparam logic [SKIP_W-1:0] SKIP_MAX = SKIP_W'(255);

	// Register reset values and default report queue depth.
	localparam logic [WIN_W-1:0] WINDOW_MS_RST = WIN_W'(1000);
	localparam logic [CAP_W-1:0] FPS_CAP_RST   = CAP_W'(60);
	localparam int FTSM_QUEUE_DEPTH = 2;

	// Operation codes and frame kinds.
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_FLUSH = 1'b1;
	localparam logic [1:0] KIND_VALID = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;

	// Configuration register indexes.
	localparam logic REG_WINDOW_MS = 1'b0;
	localparam logic REG_FPS_CAP   = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [1:0]        skip_kind;
		logic [DUR_W-1:0]  duration_ms;
		logic [DUR_W-1:0]  frame_interval_ms;
		logic [TIME_W-1:0] vsync_ms;
		logic [TIME_W-1:0] finished_ms;
		logic [TIME_W-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0]  valid_frames;
		logic [SKIP_W-1:0] empty_skipped;
		logic [SKIP_W-1:0] skipped_total;
		logic [CNT_W-1:0]  timeout_frames;
		logic [DUR_W-1:0]  min_ms;
		logic [DUR_W-1:0]  max_ms;
		logic [SUM_W-1:0]  total_ms;
		logic [FPS_W-1:0]  fps_centi;
		logic [AVG_W-1:0]  avg_centi_ms;
		logic [TIME_W-1:0] window_start_ms;
		logic [TIME_W-1:0] last_finished_ms;
		logic [TIME_W-1:0] report_time_ms;
	} out_t;

	// Snapshot of the window statistics handed from the front to the back.
	typedef struct packed {
		logic [CNT_W-1:0]  valid_frames;
		logic [SKIP_W-1:0] empty_skipped;
		logic [SKIP_W-1:0] skipped_total;
		logic [CNT_W-1:0]  timeout_frames;
		logic [DUR_W-1:0]  min_ms;
		logic [DUR_W-1:0]  max_ms;
		logic [SUM_W-1:0]  total_ms;
		logic [TIME_W-1:0] window_start_ms;
		logic [TIME_W-1:0] last_finished_ms;
		logic [TIME_W-1:0] report_time_ms;
	} rep_t;

endpackage

>>> rtl/ftsm_front.sv
module ftsm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ftsm_pkg::in_t                 in_data,
	input  logic [ftsm_pkg::WIN_W-1:0]    window_ms,
	input  logic                          q_full,
	output logic                          q_push,
	output ftsm_pkg::rep_t                q_data
);
	import ftsm_pkg::*;

	logic [CNT_W-1:0]  valid_q, n_valid;
	logic [CNT_W-1:0]  timeout_q, n_timeout;
	logic [SKIP_W-1:0] skip_q, n_skip;
	logic [SKIP_W-1:0] empty_q, n_empty;
	logic [DUR_W-1:0]  interval_q, n_interval;
	logic [TIME_W-1:0] last_fin_q, n_last_fin;
	logic [TIME_W-1:0] start_q, n_start;
	logic [SUM_W-1:0]  sum_q, n_sum;
	logic [DUR_W-1:0]  min_q, n_min;
	logic [DUR_W-1:0]  max_q, n_max;
	logic [SUM_W:0]    sum_ext;
	logic [TIME_W+1:0] elapsed;
	logic              win_done;
	logic              fire;
	logic              accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the transaction and work out the updated window state.
	always_comb begin
		n_valid    = valid_q;
		n_timeout  = timeout_q;
		n_skip     = skip_q;
		n_empty    = empty_q;
		n_interval = interval_q;
		n_last_fin = last_fin_q;
		n_start    = start_q;
		n_sum      = sum_q;
		n_min      = min_q;
		n_max      = max_q;
		sum_ext    = '0;
		if (in_data.opcode == OP_FRAME) begin
			if (in_data.skip_kind != KIND_VALID) begin
				if (in_data.skip_kind == KIND_EMPTY) begin
					n_empty = empty_q + SKIP_W'(1);
				end
				if (skip_q == SKIP_MAX) begin
					n_skip  = '0;
					n_empty = '0;
				end else begin
					n_skip = skip_q + SKIP_W'(1);
				end
			end else begin
				// The first valid frame opens the window and clears the statistics.
				if (last_fin_q == '0) begin
					n_skip    = '0;
					n_empty   = '0;
					n_timeout = '0;
					n_sum     = '0;
					n_min     = '0;
					n_max     = '0;
					n_start   = in_data.vsync_ms;
				end
				n_valid = valid_q + CNT_W'(1);
				sum_ext = {1'b0, n_sum} + (SUM_W + 1)'(in_data.duration_ms);
				n_sum   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
				if (in_data.duration_ms > n_max) begin
					n_max = in_data.duration_ms;
				end
				if (n_min == '0 || in_data.duration_ms < n_min) begin
					n_min = in_data.duration_ms;
				end
				n_interval = in_data.frame_interval_ms;
				if (in_data.frame_interval_ms != '0 &&
				    in_data.duration_ms > in_data.frame_interval_ms) begin
					n_timeout = n_timeout + CNT_W'(1);
				end
				n_last_fin = in_data.finished_ms;
			end
		end
	end

	// Window test on signed elapsed time, with no wrap.
	assign elapsed  = (TIME_W + 2)'(in_data.now_ms) - (TIME_W + 2)'(n_start)
	                + (TIME_W + 2)'(n_interval);
	assign win_done = $signed(elapsed) >= $signed((TIME_W + 2)'(window_ms));
	assign fire     = (n_last_fin != '0) && (in_data.opcode == OP_FLUSH || win_done);

	// Report snapshot pushed into the queue.
	assign q_push = accept && fire;
	always_comb begin
		q_data.valid_frames     = n_valid;
		q_data.empty_skipped    = n_empty;
		q_data.skipped_total    = n_skip;
		q_data.timeout_frames   = n_timeout;
		q_data.min_ms           = n_min;
		q_data.max_ms           = n_max;
		q_data.total_ms         = n_sum;
		q_data.window_start_ms  = n_start;
		q_data.last_finished_ms = n_last_fin;
		q_data.report_time_ms   = in_data.now_ms;
	end

	// Window state: cleared after a report, otherwise updated per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			timeout_q  <= '0;
			skip_q     <= '0;
			empty_q    <= '0;
			interval_q <= '0;
			last_fin_q <= '0;
			start_q    <= '0;
			sum_q      <= '0;
			min_q      <= '0;
			max_q      <= '0;
		end else if (accept) begin
			if (fire) begin
				valid_q    <= '0;
				timeout_q  <= '0;
				skip_q     <= '0;
				empty_q    <= '0;
				interval_q <= '0;
				last_fin_q <= '0;
				start_q    <= '0;
				sum_q      <= '0;
				min_q      <= '0;
				max_q      <= '0;
			end else begin
				valid_q    <= n_valid;
				timeout_q  <= n_timeout;
				skip_q     <= n_skip;
				empty_q    <= n_empty;
				interval_q <= n_interval;
				last_fin_q <= n_last_fin;
				start_q    <= n_start;
				sum_q      <= n_sum;
				min_q      <= n_min;
				max_q      <= n_max;
			end
		end
	end

`ifndef ASSERT_OFF
	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(skip_q <= SKIP_MAX) && (empty_q <= skip_q))
		else $error("skip counters out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("report pushed into a full queue");
	a_cleared_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> (last_fin_q == '0) && (sum_q == '0))
		else $error("state not cleared after a report");
`endif

endmodule

>>> rtl/ftsm_queue.sv
module ftsm_queue #(
	parameter int DEPTH = ftsm_pkg::FTSM_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ftsm_pkg::rep_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output ftsm_pkg::rep_t head
);
	import ftsm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QCNT_W = $clog2(DEPTH + 1);

	rep_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage for queued report snapshots.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(DEPTH))
		else $error("queue fill level beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue empty after a push");
`endif

endmodule

>>> rtl/ftsm_div.sv
module ftsm_div #(
	parameter int NUM_W = ftsm_pkg::FPS_NUM_W,
	parameter int DEN_W = ftsm_pkg::SUM_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              take;

	assign busy  = (step_q != '0);
	assign quot  = num_q;

	// One restoring step: shift in the next numerator bit and try a subtract.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});

	// The numerator register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], take};
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(NUM_W);
		end else if (busy) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

endmodule

>>> rtl/ftsm_back.sv
module ftsm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  ftsm_pkg::rep_t             q_head,
	input  logic [ftsm_pkg::CAP_W-1:0] fps_cap,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ftsm_pkg::out_t             out_data
);
	import ftsm_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                 state_q;
	rep_t                 rep_q;
	out_t                 out_q;
	logic                 out_valid_q;
	logic [FPS_NUM_W-1:0] fps_num;
	logic [AVG_NUM_W-1:0] avg_num;
	logic [FPS_NUM_W-1:0] fps_quot;
	logic [AVG_NUM_W-1:0] avg_quot;
	logic                 fps_busy;
	logic                 avg_busy;
	logic                 ld_out;
	logic [FPS_W-1:0]     capc;
	logic [FPS_W-1:0]     fps_res;
	logic [AVG_W-1:0]     avg_res;

	// Take the next report when idle; both divisions start together.
	assign q_pop   = (state_q == ST_IDLE) && !q_empty;
	assign fps_num = FPS_NUM_W'(q_head.valid_frames) * FPS_NUM_W'(FPS_SCALE);
	assign avg_num = AVG_NUM_W'(q_head.total_ms) * AVG_NUM_W'(CENTI);

	ftsm_div #(
		.NUM_W (FPS_NUM_W),
		.DEN_W (SUM_W)
	) u_fps_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (q_pop),
		.numer  (fps_num),
		.denom  (q_head.total_ms),
		.busy   (fps_busy),
		.quot   (fps_quot)
	);

	ftsm_div #(
		.NUM_W (AVG_NUM_W),
		.DEN_W (CNT_W)
	) u_avg_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (q_pop),
		.numer  (avg_num),
		.denom  (q_head.valid_frames),
		.busy   (avg_busy),
		.quot   (avg_quot)
	);

	// Clamp the frame rate to the cap and saturate the average.
	assign capc = FPS_W'(fps_cap) * FPS_W'(CENTI);
	always_comb begin
		if (rep_q.total_ms == '0 || fps_quot > FPS_NUM_W'(capc)) begin
			fps_res = capc;
		end else begin
			fps_res = fps_quot[FPS_W-1:0];
		end
		if (rep_q.valid_frames == '0) begin
			avg_res = '0;
		end else if (avg_quot > AVG_NUM_W'(AVG_SAT)) begin
			avg_res = AVG_SAT;
		end else begin
			avg_res = avg_quot[AVG_W-1:0];
		end
	end

	assign ld_out = (state_q == ST_DIV) && !fps_busy && !avg_busy &&
	                (!out_valid_q || out_ready);

	// Sequencer: wait for the dividers, then hand over to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (ld_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Snapshot of the report in progress.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rep_q <= q_head;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q.valid_frames     <= rep_q.valid_frames;
			out_q.empty_skipped    <= rep_q.empty_skipped;
			out_q.skipped_total    <= rep_q.skipped_total;
			out_q.timeout_frames   <= rep_q.timeout_frames;
			out_q.min_ms           <= rep_q.min_ms;
			out_q.max_ms           <= rep_q.max_ms;
			out_q.total_ms         <= rep_q.total_ms;
			out_q.fps_centi        <= fps_res;
			out_q.avg_centi_ms     <= avg_res;
			out_q.window_start_ms  <= rep_q.window_start_ms;
			out_q.last_finished_ms <= rep_q.last_finished_ms;
			out_q.report_time_ms   <= rep_q.report_time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> fps_busy && avg_busy)
		else $error("dividers not running after a start");
	a_load_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> !fps_busy && !avg_busy)
		else $error("result taken while a division runs");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(fps_busy || avg_busy) |-> (state_q == ST_DIV))
		else $error("divider running outside the divide state");
`endif

endmodule

>>> rtl/frame_time_stats_monitor.sv
// Windowed frame-time monitor. Each input transaction is a frame event or a flush; the front
// end takes one transaction per clock cycle while in_ready is high, updates the window
// statistics in that cycle and, when the window has run out or a flush arrives with at least
// one valid frame recorded, pushes a report snapshot into a queue of QUEUE_DEPTH entries and
// clears its state. In_ready falls only while that queue is full. The back end turns each
// queued report into one result transaction: it takes the report from the queue, runs the
// sum-times-100 by frame-count division (one quotient bit per cycle, the frame-rate division
// runs alongside), then loads the output register when free; it holds the result until taken.
// Configuration writes are accepted in every cycle: index 0 is window_ms, index 1 is fps_cap.
module frame_time_stats_monitor #(
	parameter int QUEUE_DEPTH = ftsm_pkg::FTSM_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ftsm_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ftsm_pkg::out_t             out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [ftsm_pkg::WIN_W-1:0] cfg_data
);
	import ftsm_pkg::*;

	logic [WIN_W-1:0] window_ms_q;
	logic [CAP_W-1:0] fps_cap_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	rep_t             q_wdata;
	rep_t             q_head;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= WINDOW_MS_RST;
			fps_cap_q   <= FPS_CAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_MS: window_ms_q <= cfg_data;
				REG_FPS_CAP:   fps_cap_q   <= cfg_data[CAP_W-1:0];
				default:       window_ms_q <= window_ms_q;
			endcase
		end
	end

	ftsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.window_ms (window_ms_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	ftsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	ftsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.fps_cap   (fps_cap_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
